// ===== sv/dps_pkg.sv =====
// ----------------------------------------------------------------------------
// dps_pkg
// Types, codes and the shared step function of the display power sequencer.
// ----------------------------------------------------------------------------
package dps_pkg;

	// Event codes; code seven is unused and ignored
	localparam logic [2:0] MODE_INIT   = 3'd0;
	localparam logic [2:0] MODE_WAKE   = 3'd1;
	localparam logic [2:0] MODE_SLEEP  = 3'd2;
	localparam logic [2:0] MODE_DIM    = 3'd3;
	localparam logic [2:0] MODE_LEVEL  = 3'd4;
	localparam logic [2:0] MODE_DONE   = 3'd5;
	localparam logic [2:0] MODE_CLEAR  = 3'd6;

	localparam logic [6:0] LEVEL_MAX = 7'd100;

	typedef enum logic [3:0] {
		STEP_NONE      = 4'd0,
		STEP_WAKE_OUT  = 4'd1,
		STEP_PANEL_ON  = 4'd2,
		STEP_REDRAW    = 4'd3,
		STEP_APPLY     = 4'd4,
		STEP_LIGHT_OFF = 4'd5,
		STEP_WAIT      = 4'd6,
		STEP_PANEL_OFF = 4'd7,
		STEP_SLEEP_IN  = 4'd8
	} step_t;

	typedef enum logic [1:0] {
		PWR_UNINIT = 2'd0,
		PWR_SLEEP  = 2'd1,
		PWR_DIM    = 2'd2,
		PWR_AWAKE  = 2'd3
	} pwr_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] brightness_percent;
	} evt_t;

	typedef struct packed {
		step_t      next_step;
		logic       flush_allowed;
		pwr_t       power_state;
		logic [6:0] level_now;
	} res_t;

	// Panel model and target kept between events
	typedef struct packed {
		logic       is_initialized;
		logic       light_up;
		logic       panel_enabled;
		logic       panel_wake;
		logic       redraw_needed;
		logic       transfers_quiet;
		logic       level_dirty;
		pwr_t       goal_state;
		logic [6:0] level_held;
	} dps_state_t;

	localparam dps_state_t STATE_RESET = '{
		is_initialized:  1'b0,
		light_up:        1'b0,
		panel_enabled:   1'b0,
		panel_wake:      1'b0,
		redraw_needed:   1'b0,
		transfers_quiet: 1'b0,
		level_dirty:     1'b0,
		goal_state:      PWR_UNINIT,
		level_held:      7'd0
	};

	// Step the current state calls for, in priority order
	function automatic step_t pending_step(dps_state_t s);
		step_t st;
		st = STEP_NONE;
		if (s.is_initialized) begin
			if (s.goal_state == PWR_AWAKE || s.goal_state == PWR_DIM) begin
				if (!s.panel_wake)
					st = STEP_WAKE_OUT;
				else if (!s.panel_enabled)
					st = STEP_PANEL_ON;
				else if (s.redraw_needed)
					st = STEP_REDRAW;
				else if (s.goal_state == PWR_AWAKE)
					st = (!s.light_up || s.level_dirty) ? STEP_APPLY : STEP_NONE;
				else
					st = s.light_up ? STEP_LIGHT_OFF : STEP_NONE;
			end else if (s.goal_state == PWR_SLEEP) begin
				if (s.light_up)
					st = STEP_LIGHT_OFF;
				else if (!s.transfers_quiet)
					st = STEP_WAIT;
				else if (s.panel_enabled)
					st = STEP_PANEL_OFF;
				else if (s.panel_wake)
					st = STEP_SLEEP_IN;
			end
		end
		return st;
	endfunction

endpackage

// ===== sv/dps_stream_if.sv =====
// ----------------------------------------------------------------------------
// dps_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface dps_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/dps_update.sv =====
// ----------------------------------------------------------------------------
// dps_update
// Next panel model and target after one event.
// ----------------------------------------------------------------------------
module dps_update
	import dps_pkg::*;
(
	input  dps_state_t cur,
	input  evt_t       evt,
	output dps_state_t nxt
);

	logic [6:0] req;
	step_t      step;

	// Clamp the requested level
	assign req  = (evt.brightness_percent > {1'b0, LEVEL_MAX}) ? LEVEL_MAX
		: evt.brightness_percent[6:0];
	assign step = pending_step(cur);

	// Apply the event
	always_comb begin
		nxt = cur;
		unique case (evt.mode)
			MODE_INIT: begin
				nxt.is_initialized  = 1'b1;
				nxt.light_up        = 1'b0;
				nxt.panel_enabled   = 1'b1;
				nxt.panel_wake      = 1'b1;
				nxt.redraw_needed   = 1'b1;
				nxt.transfers_quiet = 1'b0;
				nxt.level_dirty     = 1'b0;
				nxt.goal_state      = PWR_AWAKE;
				nxt.level_held      = req;
			end
			MODE_WAKE, MODE_SLEEP, MODE_DIM, MODE_LEVEL: begin
				if (cur.is_initialized) begin
					if (evt.mode == MODE_WAKE)
						nxt.goal_state = PWR_AWAKE;
					else if (evt.mode == MODE_SLEEP)
						nxt.goal_state = PWR_SLEEP;
					else if (evt.mode == MODE_DIM) begin
						if (cur.goal_state != PWR_SLEEP)
							nxt.goal_state = PWR_DIM;
					end else if (req != cur.level_held) begin
						nxt.level_held  = req;
						nxt.level_dirty = cur.light_up;
					end
					// Drop quiesce unless heading to sleep
					if (nxt.goal_state != PWR_SLEEP)
						nxt.transfers_quiet = 1'b0;
				end
			end
			MODE_DONE: begin
				case (step)
					STEP_LIGHT_OFF: begin
						nxt.light_up    = 1'b0;
						nxt.level_dirty = 1'b0;
					end
					STEP_APPLY: begin
						nxt.light_up    = 1'b1;
						nxt.level_dirty = 1'b0;
					end
					STEP_WAIT:      nxt.transfers_quiet = 1'b1;
					STEP_PANEL_OFF: nxt.panel_enabled   = 1'b0;
					STEP_PANEL_ON:  nxt.panel_enabled   = 1'b1;
					STEP_SLEEP_IN: begin
						nxt.panel_wake    = 1'b0;
						nxt.redraw_needed = 1'b1;
					end
					STEP_WAKE_OUT:  nxt.panel_wake    = 1'b1;
					STEP_REDRAW:    nxt.redraw_needed = 1'b0;
					default: ;
				endcase
			end
			MODE_CLEAR: nxt = STATE_RESET;
			default: ;
		endcase
	end

endmodule

// ===== sv/dps_status.sv =====
// ----------------------------------------------------------------------------
// dps_status
// Result word derived from the panel model after an event.
// ----------------------------------------------------------------------------
module dps_status
	import dps_pkg::*;
(
	input  dps_state_t st,
	output res_t       res
);

	// Derive step, flush permission, power state and level
	always_comb begin
		res.next_step     = pending_step(st);
		res.flush_allowed = 1'b0;
		res.power_state   = PWR_UNINIT;
		res.level_now     = st.level_held;
		if (st.is_initialized) begin
			res.flush_allowed = st.panel_wake && st.panel_enabled
				&& (st.goal_state != PWR_SLEEP);
			if (!st.panel_wake || !st.panel_enabled)
				res.power_state = PWR_SLEEP;
			else
				res.power_state = st.light_up ? PWR_AWAKE : PWR_DIM;
		end
	end

endmodule

// ===== sv/display_power_sequencer.sv =====
// ----------------------------------------------------------------------------
// display_power_sequencer
// Tracks panel power events and reports the next required step per event.
//
//   channel  dir  payload                                        role
//   evt      in   mode, brightness_percent                       one event
//   res      out  next_step, flush_allowed, power_state,         one status
//                 level_now
//
// One event per cycle while results are drained; each result appears in the cycle after its event.
// The state update and the status derivation sit between the event
// acceptance and the result register, so that register sets the latency.
// Reset clears the panel model and empties the result register.
// A new event is taken while the result register is empty or being drained;
// a stalled result holds and blocks further events.
// ----------------------------------------------------------------------------
module display_power_sequencer
	import dps_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	dps_stream_if.sink          evt,
	dps_stream_if.source        res
);

	dps_state_t state_q;
	dps_state_t state_nxt;
	res_t       res_nxt;
	res_t       res_q;
	logic       res_valid_q;
	logic       evt_take;

	assign evt.ready = !res_valid_q || res.ready;
	assign evt_take  = evt.valid && evt.ready;

	dps_update u_update (
		.cur (state_q),
		.evt (evt.data),
		.nxt (state_nxt)
	);

	dps_status u_status (
		.st  (state_nxt),
		.res (res_nxt)
	);

	// Advance the panel model on each accepted event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= STATE_RESET;
		else if (evt_take)
			state_q <= state_nxt;
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (evt_take)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (evt_take)
			res_q <= res_nxt;
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// Checks
	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		evt_take |=> res_valid_q)
		else $error("accepted event produced no result");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.level_held <= LEVEL_MAX)
		else $error("held level above maximum");

	a_goal_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.is_initialized == 1'b0) |-> (state_q.goal_state == PWR_UNINIT))
		else $error("target set while uninitialized");

	a_flush_power: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.flush_allowed) |-> (res_q.power_state != PWR_UNINIT
		&& res_q.power_state != PWR_SLEEP))
		else $error("flush allowed while panel not running");

endmodule

// ===== tb/dps_status_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_status_checker
// Watches the event and status channels of the display power sequencer,
// keeps its own model of the panel, predicts one status word per accepted
// event and compares every accepted status word with the oldest prediction.
// ----------------------------------------------------------------------------
module dps_status_checker
	import dps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        evt_valid,
	input  logic        evt_ready,
	input  evt_t        evt_data,
	input  logic        res_valid,
	input  logic        res_ready,
	input  res_t        res_data,
	output int unsigned fail_count,
	output int unsigned waiting,
	output int unsigned events_seen,
	output int unsigned status_seen
);

	// Panel model as the checker tracks it
	typedef struct packed {
		logic       inited;
		logic       lit;
		logic       powered;
		logic       awake;
		logic       redraw;
		logic       quiet;
		logic       dirty;
		pwr_t       goal;
		logic [6:0] level;
	} panel_model_t;

	localparam panel_model_t PANEL_CLEARED = '{
		inited: 1'b0, lit: 1'b0, powered: 1'b0, awake: 1'b0, redraw: 1'b0,
		quiet: 1'b0, dirty: 1'b0, goal: PWR_UNINIT, level: 7'd0
	};

	panel_model_t panel;
	res_t         status_q[$];
	int unsigned  fails;
	int unsigned  n_events;
	int unsigned  n_status;

	// Step the panel needs next, highest priority first
	function automatic step_t step_needed(panel_model_t m);
		step_t st;
		st = STEP_NONE;
		if (m.inited) begin
			case (m.goal)
				PWR_AWAKE, PWR_DIM: begin
					if (!m.awake)        st = STEP_WAKE_OUT;
					else if (!m.powered) st = STEP_PANEL_ON;
					else if (m.redraw)   st = STEP_REDRAW;
					else if (m.goal == PWR_AWAKE) begin
						if (!m.lit || m.dirty) st = STEP_APPLY;
					end else if (m.lit) begin
						st = STEP_LIGHT_OFF;
					end
				end
				PWR_SLEEP: begin
					if (m.lit)           st = STEP_LIGHT_OFF;
					else if (!m.quiet)   st = STEP_WAIT;
					else if (m.powered)  st = STEP_PANEL_OFF;
					else if (m.awake)    st = STEP_SLEEP_IN;
				end
				default: st = STEP_NONE;
			endcase
		end
		return st;
	endfunction

	// Apply one event to the panel model and derive the status word after it
	function automatic res_t predict_status(evt_t e);
		logic [6:0] req;
		res_t       r;
		req = (e.brightness_percent > {1'b0, LEVEL_MAX}) ? LEVEL_MAX
			: e.brightness_percent[6:0];
		case (e.mode)
			MODE_INIT: begin
				panel = '{inited: 1'b1, lit: 1'b0, powered: 1'b1, awake: 1'b1,
					redraw: 1'b1, quiet: 1'b0, dirty: 1'b0, goal: PWR_AWAKE, level: req};
			end
			MODE_WAKE, MODE_SLEEP, MODE_DIM, MODE_LEVEL: begin
				if (panel.inited) begin
					case (e.mode)
						MODE_WAKE:  panel.goal = PWR_AWAKE;
						MODE_SLEEP: panel.goal = PWR_SLEEP;
						MODE_DIM: begin
							if (panel.goal != PWR_SLEEP) panel.goal = PWR_DIM;
						end
						default: begin
							if (req != panel.level) begin
								panel.level = req;
								panel.dirty = panel.lit;
							end
						end
					endcase
					if (panel.goal != PWR_SLEEP) panel.quiet = 1'b0;
				end
			end
			MODE_DONE: begin
				case (step_needed(panel))
					STEP_LIGHT_OFF: begin panel.lit = 1'b0; panel.dirty = 1'b0; end
					STEP_APPLY:     begin panel.lit = 1'b1; panel.dirty = 1'b0; end
					STEP_WAIT:      panel.quiet = 1'b1;
					STEP_PANEL_OFF: panel.powered = 1'b0;
					STEP_PANEL_ON:  panel.powered = 1'b1;
					STEP_SLEEP_IN:  begin panel.awake = 1'b0; panel.redraw = 1'b1; end
					STEP_WAKE_OUT:  panel.awake = 1'b1;
					STEP_REDRAW:    panel.redraw = 1'b0;
					default: ;
				endcase
			end
			MODE_CLEAR: panel = PANEL_CLEARED;
			default: ;
		endcase

		r.next_step     = step_needed(panel);
		r.flush_allowed = panel.inited && panel.awake && panel.powered &&
			(panel.goal != PWR_SLEEP);
		if (!panel.inited)
			r.power_state = PWR_UNINIT;
		else if (!panel.awake || !panel.powered)
			r.power_state = PWR_SLEEP;
		else
			r.power_state = panel.lit ? PWR_AWAKE : PWR_DIM;
		r.level_now = panel.level;
		return r;
	endfunction

	// Compare drained words first, then queue the prediction for a new event
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			panel = PANEL_CLEARED;
			status_q.delete();
			fails = 0;
			n_events = 0;
			n_status = 0;
		end else begin
			if (res_valid && res_ready) begin
				n_status++;
				if (status_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected status word step %0d flush %0d %s",
						$time, res_data.next_step, res_data.flush_allowed,
						$sformatf("state %0d level %0d",
						res_data.power_state, res_data.level_now));
				end else begin
					want = status_q.pop_front();
					if (res_data.next_step !== want.next_step ||
						res_data.flush_allowed !== want.flush_allowed ||
						res_data.power_state !== want.power_state ||
						res_data.level_now !== want.level_now) begin
						fails++;
						$display("%0t: status mismatch, expected %s, got %s",
							$time,
							$sformatf("step %0d flush %0d state %0d level %0d",
							want.next_step, want.flush_allowed,
							want.power_state, want.level_now),
							$sformatf("step %0d flush %0d state %0d level %0d",
							res_data.next_step, res_data.flush_allowed,
							res_data.power_state, res_data.level_now));
					end
				end
			end
			if (evt_valid && evt_ready) begin
				n_events++;
				status_q.push_back(predict_status(evt_data));
			end
		end
		fail_count  <= fails;
		waiting     <= status_q.size();
		events_seen <= n_events;
		status_seen <= n_status;
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives events into the display power sequencer and drains its status
// words with random gaps and stalls; a directed pass over the edge cases is
// followed by a random mix of mostly well-formed power sequences.
// ----------------------------------------------------------------------------
module testbench;
	import dps_pkg::*;

	localparam logic [2:0] MODE_SPARE = 3'd7;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_EVENTS = 800;
	localparam int unsigned SEGMENT_LEN = 40;

	logic        clk;
	logic        arst_n;
	logic        full_rate;
	logic [7:0]  last_pct;
	int unsigned cycle_count;
	int unsigned fail_count;
	int unsigned waiting;
	int unsigned events_seen;
	int unsigned status_seen;

	dps_stream_if #(.T(evt_t)) evt_ch ();
	dps_stream_if #(.T(res_t)) res_ch ();

	display_power_sequencer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch)
	);

	dps_status_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt_valid   (evt_ch.valid),
		.evt_ready   (evt_ch.ready),
		.evt_data    (evt_ch.data),
		.res_valid   (res_ch.valid),
		.res_ready   (res_ch.ready),
		.res_data    (res_ch.data),
		.fail_count  (fail_count),
		.waiting     (waiting),
		.events_seen (events_seen),
		.status_seen (status_seen)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bound the run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d status words outstanding",
				cycle_count, waiting);
			$display("status: fail");
			$finish;
		end
	end

	// Send one event word, idling first for a random number of cycles unless at full rate
	task automatic send_event(input logic [2:0] mode, input logic [7:0] pct);
		int gap;
		gap = full_rate ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.data  <= '{mode: mode, brightness_percent: pct};
		last_pct = pct;
		do @(posedge clk); while (!evt_ch.ready);
	endtask

	// Hold off until every predicted status word has been drained
	task automatic drain_all();
		evt_ch.valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	function automatic logic [7:0] pick_pct();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0:       return 8'd0;
			1:       return 8'd100;
			2:       return 8'($urandom_range(101, 255));
			3, 4:    return last_pct;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly step done, target and level changes, rarely initialize, clear, spare or noise
	function automatic logic [2:0] pick_mode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)      return MODE_DONE;
		else if (r < 52) return MODE_WAKE;
		else if (r < 63) return MODE_SLEEP;
		else if (r < 73) return MODE_DIM;
		else if (r < 85) return MODE_LEVEL;
		else if (r < 90) return MODE_INIT;
		else if (r < 93) return MODE_CLEAR;
		else if (r < 95) return MODE_SPARE;
		else             return 3'($urandom_range(0, 7));
	endfunction

	// Status sink with random stalls
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			stall = full_rate ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// Reset, stimulus and verdict
	initial begin
		int unsigned seg;
		int unsigned k;
		evt_ch.valid = 1'b0;
		evt_ch.data  = '0;
		full_rate    = 1'b0;
		last_pct     = 8'd0;
		arst_n       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Events before initialization are ignored
		send_event(MODE_WAKE, 8'd40);
		send_event(MODE_SLEEP, 8'd0);
		send_event(MODE_DIM, 8'd0);
		send_event(MODE_LEVEL, 8'd77);
		send_event(MODE_DONE, 8'd0);
		send_event(MODE_SPARE, 8'hff);
		// Initialize with an out-of-range level, then walk to awake
		send_event(MODE_INIT, 8'd255);
		send_event(MODE_DONE, 8'd0);
		send_event(MODE_DONE, 8'd0);
		send_event(MODE_DONE, 8'd0);
		// Same level is a no-op, a new one dirties the lit backlight
		send_event(MODE_LEVEL, 8'd100);
		send_event(MODE_LEVEL, 8'd0);
		send_event(MODE_DONE, 8'd0);
		send_event(MODE_DIM, 8'd0);
		send_event(MODE_DONE, 8'd0);
		// Sleep path; dim while going to sleep is ignored
		send_event(MODE_SLEEP, 8'd0);
		send_event(MODE_DIM, 8'd0);
		send_event(MODE_DONE, 8'd0);
		send_event(MODE_DONE, 8'd0);
		send_event(MODE_DONE, 8'd0);
		// Wake back up
		send_event(MODE_WAKE, 8'd0);
		send_event(MODE_DONE, 8'd0);
		send_event(MODE_DONE, 8'd0);
		send_event(MODE_DONE, 8'd0);
		// Re-initialize, then clear back to reset
		send_event(MODE_INIT, 8'd101);
		send_event(MODE_CLEAR, 8'd0);
		drain_all();

		// Random segments, each opened by an initialize most of the time
		for (seg = 0; seg < RANDOM_EVENTS / SEGMENT_LEN; seg++) begin
			full_rate = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0)
				send_event(MODE_INIT, pick_pct());
			for (k = 0; k < SEGMENT_LEN; k++)
				send_event(pick_mode(), pick_pct());
			if (seg % 5 == 4)
				drain_all();
		end
		full_rate = 1'b0;
		evt_ch.valid <= 1'b0;

		// Wait for the last status words, then a short tail
		do @(posedge clk); while (waiting != 0);
		repeat (10) @(posedge clk);

		$display("summary: %0d events sent, %0d status words checked in %0d cycles",
			events_seen, status_seen, cycle_count);
		$display("summary: directed edge cases plus random power sequences with gaps and stalls");
		if (fail_count == 0 && waiting == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
